[src/segment_axis_plane_intersect_macros.svh]
// Assertion macros for the segment/plane intersection block.
// Standalone header; no dependencies.
`ifndef SEGMENT_AXIS_PLANE_INTERSECT_MACROS_SVH
`define SEGMENT_AXIS_PLANE_INTERSECT_MACROS_SVH
`ifndef ASSERT_OFF
`define SAPI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SAPI_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SAPI_ASSERT(label, clk, rst_n, prop, msg)
`define SAPI_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

[src/sapi_pkg.sv]
// Package for the segment/plane intersection block: payload types and codes.
// No dependencies.
`default_nettype none
package sapi_pkg;
    localparam int CoordBits = 32;
    localparam int DivBits   = 33;  // magnitudes of 33-bit deltas
    localparam int ProdBits  = 2 * DivBits;

    localparam logic [1:0] StatusHit      = 2'd0;
    localparam logic [1:0] StatusParallel = 2'd1;
    localparam logic [1:0] StatusOutside  = 2'd2;

    localparam logic [1:0] AxisX    = 2'd0;
    localparam logic [1:0] AxisY    = 2'd1;
    localparam logic [1:0] AxisZ    = 2'd2;
    localparam logic [1:0] AxisNone = 2'd3;

    typedef struct packed {
        logic [1:0]                  axis;
        logic signed [CoordBits-1:0] start_x;
        logic signed [CoordBits-1:0] start_y;
        logic signed [CoordBits-1:0] start_z;
        logic signed [CoordBits-1:0] end_x;
        logic signed [CoordBits-1:0] end_y;
        logic signed [CoordBits-1:0] end_z;
        logic signed [CoordBits-1:0] plane_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                  status;
        logic signed [CoordBits-1:0] hit_x;
        logic signed [CoordBits-1:0] hit_y;
        logic signed [CoordBits-1:0] hit_z;
    } t_out_item;

    // Per-item context carried along the divider chain.
    typedef struct packed {
        logic                        valid;
        logic [1:0]                  status;
        logic [1:0]                  axis;
        logic signed [CoordBits-1:0] plane;
        logic signed [CoordBits-1:0] s0;     // start of first other axis
        logic signed [CoordBits-1:0] s1;     // start of second other axis
        logic                        neg0;
        logic                        neg1;
        logic [DivBits-1:0]          den;
    } t_ctx;
endpackage
`default_nettype wire

[src/segment_axis_plane_intersect.sv]
// Segment vs axis-aligned plane intersection, top level.
// Result path: stage A logic, registers B and C, the divider cells, then the output register.
// Throughput: one item per cycle while not stalled; set by the 66-cell restoring divider chain.
// Whole chain advances together; it freezes when the output is full and stalled.
// Reset: synchronous active-low; clears valids, r_min_delta returns to 21.
// Depends on sapi_pkg, sapi_div_cell and the macros header.
`default_nettype none
`include "segment_axis_plane_intersect_macros.svh"
module segment_axis_plane_intersect #(
    parameter int MIN_DELTA_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire sapi_pkg::t_in_item        i_item,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output sapi_pkg::t_out_item            o_item,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [MIN_DELTA_BITS-1:0] i_cfg_data
);
    import sapi_pkg::*;

    localparam int Steps = ProdBits;

    logic [MIN_DELTA_BITS-1:0] r_min_delta;
    logic en;   // whole pipe advances

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_min_delta <= MIN_DELTA_BITS'(21);
        else if (i_cfg_valid) r_min_delta <= i_cfg_data;
    end

    assign en = !(o_valid && i_stall);
    assign o_stall = !en;

    // ---- stage A: deltas, classification ----
    logic signed [CoordBits:0] a_d [3];
    logic signed [CoordBits:0] a_da, a_n;
    logic [DivBits-1:0] a_ada, a_an;
    logic [1:0] a_status;
    logic [1:0] a_o0, a_o1;   // other axes

    always_comb begin
        a_d[0] = {i_item.end_x[CoordBits-1], i_item.end_x} -
                 {i_item.start_x[CoordBits-1], i_item.start_x};
        a_d[1] = {i_item.end_y[CoordBits-1], i_item.end_y} -
                 {i_item.start_y[CoordBits-1], i_item.start_y};
        a_d[2] = {i_item.end_z[CoordBits-1], i_item.end_z} -
                 {i_item.start_z[CoordBits-1], i_item.start_z};
        a_da = '0;
        a_n  = '0;
        a_o0 = AxisY;
        a_o1 = AxisZ;
        unique case (i_item.axis)
            AxisX: begin
                a_da = a_d[0];
                a_n = {i_item.plane_value[CoordBits-1], i_item.plane_value} -
                      {i_item.start_x[CoordBits-1], i_item.start_x};
                a_o0 = AxisY; a_o1 = AxisZ;
            end
            AxisY: begin
                a_da = a_d[1];
                a_n = {i_item.plane_value[CoordBits-1], i_item.plane_value} -
                      {i_item.start_y[CoordBits-1], i_item.start_y};
                a_o0 = AxisX; a_o1 = AxisZ;
            end
            AxisZ: begin
                a_da = a_d[2];
                a_n = {i_item.plane_value[CoordBits-1], i_item.plane_value} -
                      {i_item.start_z[CoordBits-1], i_item.start_z};
                a_o0 = AxisX; a_o1 = AxisY;
            end
            default: begin
                a_da = '0; a_n = '0;
            end
        endcase
        a_ada = a_da[CoordBits] ? DivBits'(-a_da) : DivBits'(a_da);
        a_an  = a_n[CoordBits]  ? DivBits'(-a_n)  : DivBits'(a_n);
        if (i_item.axis == AxisNone || a_ada == '0 ||
                a_ada < {{(DivBits-MIN_DELTA_BITS){1'b0}}, r_min_delta})
            a_status = StatusParallel;
        else if (a_n != '0 && ((a_n[CoordBits] != a_da[CoordBits]) || a_an > a_ada))
            a_status = StatusOutside;
        else
            a_status = StatusHit;
    end

    // register A -> B: pick other-axis deltas and starts
    t_ctx r_b_ctx;
    logic [DivBits-1:0] r_b_m0, r_b_m1, r_b_an;

    function automatic logic signed [CoordBits:0] pick_d(
        input logic [1:0] k, input logic signed [CoordBits:0] d0,
        input logic signed [CoordBits:0] d1, input logic signed [CoordBits:0] d2);
        case (k)
            AxisX:   pick_d = d0;
            AxisY:   pick_d = d1;
            default: pick_d = d2;
        endcase
    endfunction

    function automatic logic signed [CoordBits-1:0] pick_s(
        input logic [1:0] k, input t_in_item it);
        case (k)
            AxisX:   pick_s = it.start_x;
            AxisY:   pick_s = it.start_y;
            default: pick_s = it.start_z;
        endcase
    endfunction

    logic signed [CoordBits:0] a_od0, a_od1;
    always_comb begin
        a_od0 = pick_d(a_o0, a_d[0], a_d[1], a_d[2]);
        a_od1 = pick_d(a_o1, a_d[0], a_d[1], a_d[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_ctx.valid <= 1'b0;
        else if (en) r_b_ctx.valid <= i_valid;
        if (en) begin
            r_b_ctx.status <= a_status;
            r_b_ctx.axis   <= i_item.axis;
            r_b_ctx.plane  <= i_item.plane_value;
            r_b_ctx.s0     <= pick_s(a_o0, i_item);
            r_b_ctx.s1     <= pick_s(a_o1, i_item);
            r_b_ctx.neg0   <= a_od0[CoordBits] != a_n[CoordBits];
            r_b_ctx.neg1   <= a_od1[CoordBits] != a_n[CoordBits];
            r_b_ctx.den    <= a_ada;
            r_b_m0 <= a_od0[CoordBits] ? DivBits'(-a_od0) : DivBits'(a_od0);
            r_b_m1 <= a_od1[CoordBits] ? DivBits'(-a_od1) : DivBits'(a_od1);
            r_b_an <= a_an;
        end
    end

    // stage B -> C: the two 33x33 products (one multiplier each lane)
    t_ctx r_c_ctx;
    logic [ProdBits-1:0] r_c_p0, r_c_p1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_ctx.valid <= 1'b0;
        else if (en) r_c_ctx.valid <= r_b_ctx.valid;
        if (en) begin
            r_c_ctx.status <= r_b_ctx.status;
            r_c_ctx.axis   <= r_b_ctx.axis;
            r_c_ctx.plane  <= r_b_ctx.plane;
            r_c_ctx.s0     <= r_b_ctx.s0;
            r_c_ctx.s1     <= r_b_ctx.s1;
            r_c_ctx.neg0   <= r_b_ctx.neg0;
            r_c_ctx.neg1   <= r_b_ctx.neg1;
            r_c_ctx.den    <= r_b_ctx.den;
            r_c_p0 <= {{DivBits{1'b0}}, r_b_m0} * {{DivBits{1'b0}}, r_b_an};
            r_c_p1 <= {{DivBits{1'b0}}, r_b_m1} * {{DivBits{1'b0}}, r_b_an};
        end
    end

    // ---- divider chain: one quotient bit per cell ----
    t_ctx                c_ctx  [Steps+1];
    logic [ProdBits-1:0] c_num0 [Steps+1];
    logic [ProdBits-1:0] c_num1 [Steps+1];
    logic [DivBits:0]    c_rem0 [Steps+1];
    logic [DivBits:0]    c_rem1 [Steps+1];

    assign c_ctx[0]  = r_c_ctx;
    assign c_num0[0] = r_c_p0;
    assign c_num1[0] = r_c_p1;
    assign c_rem0[0] = '0;
    assign c_rem1[0] = '0;

    for (genvar g = 0; g < Steps; g++) begin : g_cell
        sapi_div_cell #(.STEP(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_ctx  (c_ctx[g]),
            .i_num0 (c_num0[g]),
            .i_num1 (c_num1[g]),
            .i_rem0 (c_rem0[g]),
            .i_rem1 (c_rem1[g]),
            .o_ctx  (c_ctx[g+1]),
            .o_num0 (c_num0[g+1]),
            .o_num1 (c_num1[g+1]),
            .o_rem0 (c_rem0[g+1]),
            .o_rem1 (c_rem1[g+1])
        );
    end

    // ---- final assembly into output register ----
    t_ctx f_ctx;
    logic signed [CoordBits-1:0] f_q0, f_q1, f_r0, f_r1;
    t_out_item f_item;
    always_comb begin
        f_ctx = c_ctx[Steps];
        f_q0 = CoordBits'(c_num0[Steps]);
        f_q1 = CoordBits'(c_num1[Steps]);
        f_r0 = f_ctx.neg0 ? f_ctx.s0 - f_q0 : f_ctx.s0 + f_q0;
        f_r1 = f_ctx.neg1 ? f_ctx.s1 - f_q1 : f_ctx.s1 + f_q1;
        f_item = '0;
        f_item.status = f_ctx.status;
        if (f_ctx.status == StatusHit) begin
            unique case (f_ctx.axis)
                AxisX: begin
                    f_item.hit_x = f_ctx.plane; f_item.hit_y = f_r0; f_item.hit_z = f_r1;
                end
                AxisY: begin
                    f_item.hit_x = f_r0; f_item.hit_y = f_ctx.plane; f_item.hit_z = f_r1;
                end
                default: begin
                    f_item.hit_x = f_r0; f_item.hit_y = f_r1; f_item.hit_z = f_ctx.plane;
                end
            endcase
        end
    end

    logic r_out_valid;
    t_out_item r_out_item;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (en) r_out_valid <= f_ctx.valid;
        if (en) r_out_item <= f_item;
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    `SAPI_ASSERT(a_stall_holds_out, i_clk, i_rst_n,
        o_valid && i_stall |=> o_valid && $stable(o_item), "output changed while stalled")
    `SAPI_ASSERT(a_miss_zero, i_clk, i_rst_n,
        o_valid && o_item.status != StatusHit |->
        o_item.hit_x == '0 && o_item.hit_y == '0 && o_item.hit_z == '0,
        "miss with nonzero coordinates")
    `SAPI_ASSERT(a_status_range, i_clk, i_rst_n,
        o_valid |-> o_item.status != 2'd3, "bad status code")
    `SAPI_ASSERT_RST(a_reset_clears, i_clk,
        !i_rst_n |=> !o_valid, "output valid after reset")
endmodule
`default_nettype wire

[src/sapi_div_cell.sv]
// One restoring-division step cell for the two quotient lanes.
// Depends on sapi_pkg.
`default_nettype none
module sapi_div_cell #(
    parameter int STEP = 0
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire sapi_pkg::t_ctx                i_ctx,
    input  wire logic [sapi_pkg::ProdBits-1:0] i_num0,
    input  wire logic [sapi_pkg::ProdBits-1:0] i_num1,
    input  wire logic [sapi_pkg::DivBits:0]    i_rem0,
    input  wire logic [sapi_pkg::DivBits:0]    i_rem1,
    output sapi_pkg::t_ctx                     o_ctx,
    output logic [sapi_pkg::ProdBits-1:0]      o_num0,
    output logic [sapi_pkg::ProdBits-1:0]      o_num1,
    output logic [sapi_pkg::DivBits:0]         o_rem0,
    output logic [sapi_pkg::DivBits:0]         o_rem1
);
    import sapi_pkg::*;

    localparam int Bit = ProdBits - 1 - STEP;

    logic [DivBits+1:0] n_t0, n_t1;
    logic [DivBits:0]   n_rem0, n_rem1;
    logic               n_q0, n_q1;
    logic [ProdBits-1:0] n_num0, n_num1;

    always_comb begin
        n_t0 = {i_rem0, i_num0[Bit]};
        n_t1 = {i_rem1, i_num1[Bit]};
        n_q0 = n_t0 >= {1'b0, 1'b0, i_ctx.den};
        n_q1 = n_t1 >= {1'b0, 1'b0, i_ctx.den};
        n_rem0 = n_q0 ? (DivBits+1)'(n_t0 - {2'b0, i_ctx.den}) : n_t0[DivBits:0];
        n_rem1 = n_q1 ? (DivBits+1)'(n_t1 - {2'b0, i_ctx.den}) : n_t1[DivBits:0];
        n_num0 = i_num0;
        n_num1 = i_num1;
        n_num0[Bit] = n_q0;   // quotient bit replaces consumed numerator bit
        n_num1[Bit] = n_q1;
    end

    t_ctx r_ctx;
    logic [ProdBits-1:0] r_num0, r_num1;
    logic [DivBits:0]    r_rem0, r_rem1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx.valid <= 1'b0;
        end else if (i_en) begin
            r_ctx.valid <= i_ctx.valid;
        end
        if (i_en) begin
            r_ctx.status <= i_ctx.status;
            r_ctx.axis   <= i_ctx.axis;
            r_ctx.plane  <= i_ctx.plane;
            r_ctx.s0     <= i_ctx.s0;
            r_ctx.s1     <= i_ctx.s1;
            r_ctx.neg0   <= i_ctx.neg0;
            r_ctx.neg1   <= i_ctx.neg1;
            r_ctx.den    <= i_ctx.den;
            r_num0 <= n_num0;
            r_num1 <= n_num1;
            r_rem0 <= n_rem0;
            r_rem1 <= n_rem1;
        end
    end

    assign o_ctx  = r_ctx;
    assign o_num0 = r_num0;
    assign o_num1 = r_num1;
    assign o_rem0 = r_rem0;
    assign o_rem1 = r_rem1;
endmodule
`default_nettype wire
